>>> hdl/iscf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image slot cache package
// Shared widths, table entry types, register indexes and controller states.
// ----------------------------------------------------------------------------
package iscf_pkg;

  localparam int MAX_CAMERAS = 1024;
  localparam int MAX_SLOTS   = 64;

  localparam int CAM_W   = $clog2(MAX_CAMERAS);
  localparam int SLOT_W  = $clog2(MAX_SLOTS);
  localparam int NSLOT_W = SLOT_W + 1;
  localparam int CCNT_W  = CAM_W + 1;
  localparam int CFG_W   = 11;

  // Configuration register indexes.
  localparam logic CFG_SLOTS_IN_USE = 1'b0;
  localparam logic CFG_CAMERA_COUNT = 1'b1;

  // One entry of the camera-to-slot table.
  typedef struct packed {
    logic              mapped;
    logic [SLOT_W-1:0] slot;
  } fwd_entry_t;

  // Write request into the camera-to-slot table.
  typedef struct packed {
    logic             en;
    logic [CAM_W-1:0] addr;
    fwd_entry_t       data;
  } fwd_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVICT
  } ctrl_state_t;

endpackage

>>> hdl/image_slot_cache_fifo_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image slot cache with FIFO replacement
// Maps camera numbers to cache slots and picks victims by a rotating pointer.
// ----------------------------------------------------------------------------
// Usage:
// A request carries in_camera_id on a valid/ready channel. Each request gives
// exactly one result on the out_ channel: hit and slot, or on a miss the slot
// to load and any camera evicted from it, or range_error for a camera number
// not below camera_count (nothing changes then).
// The result is registered from the lookup state, once the output register is
// free. A request passes through the idle and lookup states, and on a miss
// that evicts a camera also the evict state, as the camera-to-slot table has
// one write port and the eviction needs a second write. The next request is
// taken while a finished result still waits in the output register; a stalled
// receiver only holds the block once a further result is ready to be written.
// After reset the camera-to-slot table is swept clear, one entry a cycle;
// no request is taken during the sweep, while configuration writes are
// taken at any time. slots_in_use resets to 64 and camera_count to 1024.
// ----------------------------------------------------------------------------
module image_slot_cache_fifo_replacement_unit
  import iscf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CAM_W-1:0]  in_camera_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_load_needed,
  output logic              out_evicted_valid,
  output logic [CAM_W-1:0]  out_evicted_camera,
  output logic              out_range_error
);

  ctrl_state_t         state_r, state_nxt;
  logic [NSLOT_W-1:0]  slots_in_use_r;
  logic [CCNT_W-1:0]   camera_count_r;
  logic [SLOT_W-1:0]   ptr_r;

  logic [CAM_W-1:0]    cam_r;
  logic                range_err_r;
  logic [SLOT_W-1:0]   victim_r;
  logic                old_full_r;
  logic [CAM_W-1:0]    old_cam_r;

  logic [CAM_W-1:0]    rev_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] slot_full_r;

  logic                out_valid_r;
  logic                hit_r, load_r, ev_valid_r, rerr_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [CAM_W-1:0]    ev_cam_r;

  logic                in_xfer, out_free, clear_busy;
  logic                do_result, install;
  logic [NSLOT_W-1:0]  n_act, victim_ext, next_ext;
  logic [SLOT_W-1:0]   victim;
  fwd_entry_t          fwd_q;
  fwd_wr_t             fwd_wr;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Active slot count, clamped to one through the table size.
  always_comb begin
    n_act = slots_in_use_r;
    if (slots_in_use_r == '0) begin
      n_act = NSLOT_W'(1);
    end else if (slots_in_use_r > NSLOT_W'(MAX_SLOTS)) begin
      n_act = NSLOT_W'(MAX_SLOTS);
    end
  end

  // Victim restarts at slot 0 if the pointer lies beyond the active slots.
  assign victim_ext = ({1'b0, ptr_r} < n_act) ? {1'b0, ptr_r} : '0;
  assign victim     = victim_ext[SLOT_W-1:0];

  // Pointer advance after a victim in flight, wrapping at the active count.
  always_comb begin
    next_ext = {1'b0, victim_r} + 1'b1;
    if (next_ext >= n_act) begin
      next_ext = '0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= NSLOT_W'(MAX_SLOTS);
      camera_count_r <= CCNT_W'(MAX_CAMERAS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOTS_IN_USE: slots_in_use_r <= cfg_data[NSLOT_W-1:0];
        CFG_CAMERA_COUNT: camera_count_r <= cfg_data[CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  iscf_fwd_map u_fwd_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_xfer),
    .rd_addr    (in_camera_id),
    .rd_data    (fwd_q),
    .wr         (fwd_wr),
    .clear_busy (clear_busy)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          if (!range_err_r && !fwd_q.mapped && old_full_r) begin
            state_nxt = ST_EVICT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EVICT: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs and table write requests.
  always_comb begin
    in_ready    = 1'b0;
    do_result   = 1'b0;
    install     = 1'b0;
    fwd_wr      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !clear_busy;
      end
      ST_LOOKUP: begin
        do_result = out_free;
        install   = out_free && !range_err_r && !fwd_q.mapped;
        if (install) begin
          fwd_wr.en          = 1'b1;
          fwd_wr.addr        = cam_r;
          fwd_wr.data.mapped = 1'b1;
          fwd_wr.data.slot   = victim_r;
        end
      end
      ST_EVICT: begin
        // Unmap the camera that used to sit in the victim slot.
        fwd_wr.en   = 1'b1;
        fwd_wr.addr = old_cam_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request and read the victim's slot entry on transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cam_r       <= in_camera_id;
      range_err_r <= ({1'b0, in_camera_id} >= camera_count_r);
      victim_r    <= victim;
      old_full_r  <= slot_full_r[victim];
      old_cam_r   <= rev_mem[victim];
    end
  end

  // Slot-to-camera table.
  always_ff @(posedge clk) begin
    if (install) begin
      rev_mem[victim_r] <= cam_r;
    end
  end

  // Slot occupancy flags and replacement pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_full_r <= '0;
      ptr_r       <= '0;
    end else if (install) begin
      slot_full_r[victim_r] <= 1'b1;
      ptr_r                 <= next_ext[SLOT_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_result) begin
      hit_r      <= 1'b0;
      slot_r     <= '0;
      load_r     <= 1'b0;
      ev_valid_r <= 1'b0;
      ev_cam_r   <= '0;
      rerr_r     <= range_err_r;
      if (!range_err_r) begin
        if (fwd_q.mapped) begin
          hit_r  <= 1'b1;
          slot_r <= fwd_q.slot;
        end else begin
          slot_r     <= victim_r;
          load_r     <= 1'b1;
          ev_valid_r <= old_full_r;
          ev_cam_r   <= old_full_r ? old_cam_r : '0;
        end
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = hit_r;
  assign out_slot           = slot_r;
  assign out_load_needed    = load_r;
  assign out_evicted_valid  = ev_valid_r;
  assign out_evicted_camera = ev_cam_r;
  assign out_range_error    = rerr_r;

endmodule

>>> hdl/iscf_fwd_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera-to-slot table
// Single-port-write memory with a registered read, swept clear after reset.
// ----------------------------------------------------------------------------
module iscf_fwd_map
  import iscf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [CAM_W-1:0] rd_addr,
  output fwd_entry_t       rd_data,
  input  fwd_wr_t          wr,
  output logic             clear_busy
);

  fwd_entry_t         mem [MAX_CAMERAS];
  fwd_entry_t         rd_data_r;
  logic [CAM_W:0]     clr_cnt_r;
  logic [CAM_W:0]     clr_cnt_nxt;

  assign clear_busy = (clr_cnt_r != (CAM_W + 1)'(MAX_CAMERAS));
  assign rd_data    = rd_data_r;

  // The sweep counter walks every entry once after reset.
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    if (clear_busy) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // The clearing sweep owns the write port until it finishes.
  always_ff @(posedge clk) begin
    if (clear_busy) begin
      mem[clr_cnt_r[CAM_W-1:0]] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
